>>> hdl/u8u2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2d_pkg - shared types and constants of the UTF-8 to UCS-2 decoder
// Job format passed from the front end to the emit stage, reset values.
// ----------------------------------------------------------------------------
package u8u2d_pkg;

    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GRP_MAX     = 4;
    localparam int unsigned IDX_W       = 2;

    localparam logic [UNIT_W-1:0] REPL_CHAR_RESET = 16'd63;
    localparam int unsigned       QUEUE_DEPTH_DEF = 4;

    // One job: all results caused by one input byte.
    typedef struct packed {
        logic [GRP_MAX-1:0][BYTE_W-1:0] grp_bytes;   // raw bytes, in order
        logic [UNIT_W-1:0]              unit;        // decoded or pass unit
        logic                           raw;         // 1: emit grp_bytes raw
        logic [IDX_W-1:0]               last_idx;    // results minus one
        logic                           stream_end;  // job ends the string
    } job_t;

    // Queue head as seen by the emit stage.
    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

endpackage
`default_nettype wire

>>> hdl/u8u2d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2d_front - byte classifier and group tracker
// Takes one byte per beat, tracks the open group and builds a job for each byte that yields results.
// ----------------------------------------------------------------------------
module u8u2d_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    input  logic [15:0]                   repl_char,
    input  logic                          q_full,
    output logic                          q_push,
    output u8u2d_pkg::job_t               q_job
);

    logic [7:0] held_reg [3];
    logic [1:0] count_reg, count_next;
    logic [2:0] size_reg,  size_next;
    logic       ok_reg,    ok_next;

    logic       accept;
    logic [2:0] lead_size;
    logic       ok_cur;
    logic       complete;
    logic       hold_wr;

    assign in_ready = ~q_full;
    assign accept   = in_valid & ~q_full;

    // Lead byte length: 0 for bytes that open no group
    always_comb
    begin
        if ((in_byte & 8'hF8) == 8'hF0)
            lead_size = 3'd4;
        else if ((in_byte & 8'hF0) == 8'hE0)
            lead_size = 3'd3;
        else if ((in_byte & 8'hE0) == 8'hC0)
            lead_size = 3'd2;
        else
            lead_size = 3'd0;
    end

    assign ok_cur   = ok_reg & ((in_byte & 8'hC0) == 8'h80);
    assign complete = ({1'b0, count_reg} + 3'd1) >= size_reg;

    always_comb
    begin
        count_next = count_reg;
        size_next  = size_reg;
        ok_next    = ok_reg;
        hold_wr    = 1'b0;
        q_push     = 1'b0;

        q_job.grp_bytes[0] = (count_reg > 2'd0) ? held_reg[0] : in_byte;
        q_job.grp_bytes[1] = (count_reg > 2'd1) ? held_reg[1] : in_byte;
        q_job.grp_bytes[2] = (count_reg > 2'd2) ? held_reg[2] : in_byte;
        q_job.grp_bytes[3] = in_byte;
        q_job.unit         = {8'h00, in_byte};
        q_job.raw          = 1'b0;
        q_job.last_idx     = 2'd0;
        q_job.stream_end   = in_last;

        if (count_reg == 2'd0)
        begin
            if (lead_size == 3'd0)
            begin
                q_push = accept;
            end
            else if (in_last)
            begin
                q_push    = accept;
                q_job.raw = 1'b1;
            end
            else if (accept)
            begin
                hold_wr    = 1'b1;
                count_next = 2'd1;
                size_next  = lead_size;
                ok_next    = 1'b1;
            end
        end
        else if (complete)
        begin
            q_push = accept;
            if (ok_cur)
            begin
                if (size_reg == 3'd2)
                    q_job.unit = {5'd0, held_reg[0][4:0], in_byte[5:0]};
                else if (size_reg == 3'd3)
                    q_job.unit = {held_reg[0][3:0], held_reg[1][5:0], in_byte[5:0]};
                else
                    q_job.unit = repl_char;
            end
            else
            begin
                q_job.raw      = 1'b1;
                q_job.last_idx = count_reg;
            end
            if (accept)
            begin
                count_next = 2'd0;
                size_next  = 3'd0;
                ok_next    = 1'b1;
            end
        end
        else if (in_last)
        begin
            // string ends inside a group: flush everything raw
            q_push         = accept;
            q_job.raw      = 1'b1;
            q_job.last_idx = count_reg;
            if (accept)
            begin
                count_next = 2'd0;
                size_next  = 3'd0;
                ok_next    = 1'b1;
            end
        end
        else if (accept)
        begin
            hold_wr    = 1'b1;
            count_next = count_reg + 2'd1;
            ok_next    = ok_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            size_reg  <= 3'd0;
            ok_reg    <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            size_reg  <= size_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_wr && (count_reg != 2'd3))
            held_reg[count_reg] <= in_byte;
    end

endmodule
`default_nettype wire

>>> hdl/u8u2d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2d_queue - job queue between front end and emit stage
// Small circular buffer; head is presented with a valid flag.
// ----------------------------------------------------------------------------
module u8u2d_queue #(
    parameter int unsigned DEPTH = u8u2d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u8u2d_pkg::job_t      push_job,
    output logic                 full,
    input  logic                 pop,
    output u8u2d_pkg::q_head_t   head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u8u2d_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg,    cnt_next;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    assign do_push = push & ~full;
    assign do_pop  = pop & head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

>>> hdl/u8u2d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8u2d_back - result emitter
// Walks each queued job one result per beat into the output register.
// ----------------------------------------------------------------------------
module u8u2d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8u2d_pkg::q_head_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          code_unit,
    output logic                 unit_raw,
    output logic                 run_last,
    output logic                 stream_end
);

    logic        valid_reg;
    logic [15:0] unit_reg;
    logic        raw_reg, run_last_reg, end_reg;
    logic [1:0]  idx_reg, idx_next;

    logic        load_en;
    logic        load;
    logic        is_last;

    assign load_en = ~valid_reg | out_ready;
    assign load    = load_en & head.valid;
    assign is_last = (idx_reg == head.job.last_idx);
    assign pop     = load & is_last;
    assign idx_next = pop ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load_en)
                valid_reg <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg     <= head.job.raw ? {8'h00, head.job.grp_bytes[idx_reg]}
                                         : head.job.unit;
            raw_reg      <= head.job.raw;
            run_last_reg <= is_last;
            end_reg      <= is_last & head.job.stream_end;
        end
    end

    assign out_valid  = valid_reg;
    assign code_unit  = unit_reg;
    assign unit_raw   = raw_reg;
    assign run_last   = run_last_reg;
    assign stream_end = end_reg;

endmodule
`default_nettype wire

>>> hdl/utf8_to_ucs2_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_core - UTF-8 byte stream to 16-bit code units
// Front end tracks lead/continuation groups, a job queue decouples it from
// the emit stage that drives one result per beat.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per beat on the in channel (in_last marks the final
// byte of a string) and gives 16-bit UCS-2 units on the out channel. A lead
// byte opens a 2-, 3- or 4-byte group that consumes up to that many bytes;
// a well-formed 2/3-byte group yields one decoded unit, a well-formed 4-byte
// group yields the replacement_char register value (reset 0x003F). A group
// with a bad follower, or one cut short by in_last, comes out byte by byte,
// zero-extended, with unit_raw set. ASCII and stray bytes pass through with
// unit_raw clear. run_last flags the last result caused by an input beat,
// stream_end the final result of the string. Rate: the front end takes a
// byte every cycle as long as the job queue (QUEUE_DEPTH jobs) has room;
// the emit stage drives one result per cycle while out_ready is high, so a
// raw flush of n bytes comes out as n results. Results never outnumber bytes,
// so with out_ready high the sustained rate is one byte per cycle. A finished
// job is registered in the job queue, its results then in the output register.
// Write replacement_char through cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = u8u2d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    // unit output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        unit_raw,
    output logic        run_last,
    output logic        stream_end
);

    logic [15:0]        repl_char_reg;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    u8u2d_pkg::job_t    q_job;
    u8u2d_pkg::q_head_t q_head;

    // Configuration register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_char_reg <= u8u2d_pkg::REPL_CHAR_RESET;
        else if (cfg_valid)
            repl_char_reg <= cfg_data;
    end

    // Front end: classify bytes, hold open group, build jobs.
    u8u2d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .repl_char (repl_char_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Job queue between the two halves.
    u8u2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    // Emit stage: one result per beat into the output register.
    u8u2d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .unit_raw   (unit_raw),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    // Front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job pushed into full queue");

    // End of string is always on the last result of its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_end) |-> run_last)
        else $error("stream_end without run_last");

    // Decoded and pass-through units stand alone for their beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !unit_raw) |-> run_last)
        else $error("non-raw unit not last of its beat");

endmodule
`default_nettype wire
